### hw/rtl/smsrng_pkg.sv
// types and constants of the shuffled minimal standard generator
package smsrng_pkg;

   // input word
   typedef struct packed {
      logic               operation;
      logic signed [31:0] seed_value;
   } req_type;

   // result word
   typedef struct packed {
      logic [30:0] sample;
      logic [23:0] fraction;
      logic [30:0] seed_after;
   } rsp_type;

   // operation codes
   localparam logic OP_DRAW      = 1'b0;
   localparam logic OP_LOAD_DRAW = 1'b1;

   // generator constants
   localparam logic [14:0] MULT       = 15'd16807;
   localparam logic [30:0] MODULUS    = 31'h7FFF_FFFF;
   localparam logic [23:0] FRAC_MAX   = 24'd16777213;
   localparam int          WARM_EXTRA = 8;

   // sequencer states
   typedef enum logic [5:0] {
      ST_IDLE      = 6'b000001,
      ST_WARM_MUL  = 6'b000010,
      ST_WARM_FOLD = 6'b000100,
      ST_DRAW_MUL  = 6'b001000,
      ST_DRAW_FOLD = 6'b010000,
      ST_DRAW_WB   = 6'b100000
   } state_type;

endpackage

### hw/rtl/smsrng_ram.sv
// generic simple dual port ram with registered read
module smsrng_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### hw/rtl/shuffled_minimal_standard_rng_top.sv
// shuffled minimal standard generator: sequencer, modular multiplier and shuffle table
//
// Usage: raise start with a word on req_data while busy is low; the word is taken
// at that clock edge. operation OP_DRAW draws with the stored seed, OP_LOAD_DRAW
// loads seed_value first. Each word gives exactly one result word on rsp_data,
// shown for one cycle with rsp_strobe high; the receiver cannot stall it.
// A draw from a seeded generator passes through the fold and write-back states
// with busy high, and its result is registered out of write-back; no new word is
// taken until the block is idle again. The modular step is a registered multiply,
// then the Mersenne fold, and the table slot is read and rewritten through one RAM.
// When the generator must seed itself (after reset, on a seed that is not
// positive, on a zero stored seed or on a zero last output) it first runs
// TABLE_SIZE+8 warm-up steps, each a multiply and a fold, and one more multiply.
// Reset (synchronous, active high) clears the seed and the last output, which
// forces seeding on the first draw; the table needs no clearing since seeding
// fills every slot before any slot is read.
module shuffled_minimal_standard_rng_top #(
   parameter int TABLE_SIZE = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  smsrng_pkg::req_type req_data,
   output logic                rsp_strobe,
   output smsrng_pkg::rsp_type rsp_data
);

   import smsrng_pkg::*;

   localparam int IDX_W = $clog2(TABLE_SIZE);
   localparam int CNT_W = $clog2(TABLE_SIZE + WARM_EXTRA);
   localparam int Q_W   = $clog2(TABLE_SIZE + 2);
   localparam longint SLOT_DIV_L = 64'd1 + (64'd2147483646 / TABLE_SIZE);
   localparam longint RECIP_L    = (64'd1 << 31) / SLOT_DIV_L;
   localparam logic [30:0]      SLOT_DIV   = SLOT_DIV_L[30:0];
   localparam logic [Q_W-1:0]   RECIP      = RECIP_L[Q_W-1:0];
   localparam logic [CNT_W-1:0] WARM_START = CNT_W'(TABLE_SIZE + WARM_EXTRA - 1);
   localparam logic [CNT_W-1:0] TABLE_LAST = CNT_W'(TABLE_SIZE - 1);
   localparam logic [Q_W-1:0]   SLOT_TOP   = Q_W'(TABLE_SIZE - 1);

   // reduce a product of up to 47 bits modulo 2^31-1
   function automatic logic [30:0] fold_mod(input logic [46:0] p);
      logic [31:0] sum;
      logic [31:0] red;
      sum = {1'b0, p[30:0]} + {16'b0, p[46:31]};
      red = sum - {1'b0, MODULUS};
      fold_mod = (sum >= {1'b0, MODULUS}) ? red[30:0] : sum[30:0];
   endfunction

   state_type        state_ff, state_in;
   logic [30:0]      seed_reg_ff, seed_reg_in;
   logic [30:0]      last_ff, last_in;
   logic [31:0]      s_ff, s_in;
   logic [46:0]      prod_ff, prod_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [Q_W-1:0]   q_est_ff, q_est_in;
   logic [IDX_W-1:0] slot_ff, slot_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   rsp_type          rsp_ff, rsp_in;

   logic             accept;
   logic             neg;
   logic [31:0]      mag;
   logic             need_seed;
   logic [31:0]      mul_a;
   logic [30:0]      folded;
   logic [Q_W+30:0]  est_prod;
   logic [Q_W+30:0]  back_prod;
   logic [Q_W+30:0]  rem;
   logic [Q_W-1:0]   q_fix;
   logic [Q_W-1:0]   q_sat;
   logic             ram_we;
   logic [IDX_W-1:0] ram_waddr;
   logic [30:0]      ram_wdata;
   logic [30:0]      ram_rdata;
   logic [23:0]      frac_a;
   logic [31:0]      frac_sum;
   logic [24:0]      frac_q;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   // incoming seed: negate negative seeds, take the stored seed on a plain draw
   always_comb begin
      neg = (req_data.operation == OP_LOAD_DRAW) && req_data.seed_value[31];
      if (req_data.operation == OP_LOAD_DRAW) begin
         mag = neg ? (32'd0 - req_data.seed_value) : req_data.seed_value;
      end else begin
         mag = {1'b0, seed_reg_ff};
      end
      need_seed = neg || (mag == 32'd0) || (last_ff == 31'd0);
   end

   // shared modular multiplier, folded from the registered product
   assign mul_a   = (state_ff == ST_IDLE) ? mag : s_ff;
   assign prod_in = {15'b0, mul_a} * {32'b0, MULT};
   assign folded  = fold_mod(prod_ff);

   // slot of the last output: reciprocal estimate, then one correction step
   assign est_prod  = {{Q_W{1'b0}}, last_ff} * {31'b0, RECIP};
   assign q_est_in  = est_prod[Q_W+30:31];
   assign back_prod = {{Q_W{1'b0}}, SLOT_DIV} * {31'b0, q_est_ff};
   assign rem       = {{Q_W{1'b0}}, last_ff} - back_prod;
   assign q_fix     = (rem >= {{Q_W{1'b0}}, SLOT_DIV}) ? (q_est_ff + Q_W'(1)) : q_est_ff;
   assign q_sat     = (q_fix > SLOT_TOP) ? SLOT_TOP : q_fix;
   assign slot_in   = (state_ff == ST_DRAW_FOLD) ? q_sat[IDX_W-1:0] : slot_ff;

   // fraction: floor(x*2^24/(2^31-1)) via the Mersenne identity, clamped
   always_comb begin
      frac_a   = ram_rdata[30:7];
      frac_sum = {8'b0, frac_a} + {1'b0, ram_rdata[6:0], 24'b0};
      frac_q   = {1'b0, frac_a} + ((frac_sum >= {1'b0, MODULUS}) ? 25'd1 : 25'd0);
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      seed_reg_in   = seed_reg_ff;
      last_in       = last_ff;
      s_in          = s_ff;
      count_in      = count_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      ram_we        = 1'b0;
      ram_waddr     = slot_ff;
      ram_wdata     = s_ff[30:0];
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (need_seed) begin
                  s_in     = neg ? mag : 32'd1;
                  count_in = WARM_START;
                  state_in = ST_WARM_MUL;
               end else begin
                  state_in = ST_DRAW_FOLD;
               end
            end
         end
         ST_WARM_MUL: begin
            state_in = ST_WARM_FOLD;
         end
         ST_WARM_FOLD: begin
            s_in      = {1'b0, folded};
            ram_waddr = count_ff[IDX_W-1:0];
            ram_wdata = folded;
            ram_we    = (count_ff <= TABLE_LAST);
            if (count_ff == '0) begin
               last_in  = folded;
               state_in = ST_DRAW_MUL;
            end else begin
               count_in = count_ff - CNT_W'(1);
               state_in = ST_WARM_MUL;
            end
         end
         ST_DRAW_MUL: begin
            state_in = ST_DRAW_FOLD;
         end
         ST_DRAW_FOLD: begin
            s_in     = {1'b0, folded};
            state_in = ST_DRAW_WB;
         end
         ST_DRAW_WB: begin
            ram_we              = 1'b1;
            last_in             = ram_rdata;
            seed_reg_in         = s_ff[30:0];
            rsp_strobe_in       = 1'b1;
            rsp_in.sample       = ram_rdata;
            rsp_in.fraction     = (frac_q > {1'b0, FRAC_MAX}) ? FRAC_MAX : frac_q[23:0];
            rsp_in.seed_after   = s_ff[30:0];
            state_in            = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         seed_reg_ff   <= '0;
         last_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         seed_reg_ff   <= seed_reg_in;
         last_ff       <= last_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      s_ff     <= s_in;
      prod_ff  <= prod_in;
      count_ff <= count_in;
      q_est_ff <= q_est_in;
      slot_ff  <= slot_in;
      rsp_ff   <= rsp_in;
   end

   // shuffle table: read in the fold cycle, rewritten in the write-back cycle
   smsrng_ram #(
      .WIDTH (31),
      .DEPTH (TABLE_SIZE)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (slot_in),
      .rd_data (ram_rdata)
   );

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

`ifndef SYNTHESIS
   // state register stays one-hot
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register not one-hot");

   // an accepted word makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted word did not raise busy");

   // a result appears only right after write-back and the block is then idle
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (!busy && $past(state_ff == ST_DRAW_WB)))
      else $error("result strobe outside write-back");

   // results stay inside their ranges
   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((rsp_data.fraction <= FRAC_MAX) && (rsp_data.seed_after != MODULUS)))
      else $error("result out of range");
`endif

endmodule

### dv/shuffled_minimal_standard_rng_top_tb.sv
// self-checking testbench of the shuffled minimal standard generator: directed table, then random words
module shuffled_minimal_standard_rng_top_tb;
   import smsrng_pkg::*;

   localparam int          TABLE_SIZE   = 32;
   localparam logic [63:0] SLOT_DIV     = 64'd1 + 64'(MODULUS - 31'd1) / 64'(TABLE_SIZE);
   localparam int          RANDOM_WORDS = 650;
   localparam int          TAIL_CYCLES  = 2 * (TABLE_SIZE + WARM_EXTRA) + 20;
   localparam int          CYCLE_LIMIT  = 600000;

   // one row of the directed table; seed_after is typed in only where pinned
   typedef struct packed {
      logic        operation;
      logic [31:0] seed_value;
      logic        pinned;
      logic [30:0] seed_after;
   } stim_row_type;

   typedef struct packed {
      logic        known;
      logic [30:0] seed_after;
   } seed_hint_type;

   localparam int N_DIRECTED = 18;
   stim_row_type directed_rows [N_DIRECTED] = '{
      // positive seed while unseeded becomes 1
      '{OP_LOAD_DRAW, 32'h0000_3039, 1'b0, 31'd0},
      '{OP_DRAW,      32'hFFFF_FFFF, 1'b0, 31'd0},
      // zero seed reseeds from 1
      '{OP_LOAD_DRAW, 32'h0000_0000, 1'b0, 31'd0},
      '{OP_LOAD_DRAW, 32'h0000_0001, 1'b0, 31'd0},
      // largest positive seed steps to zero
      '{OP_LOAD_DRAW, 32'h7FFF_FFFF, 1'b1, 31'd0},
      // zero stored seed forces reseeding
      '{OP_DRAW,      32'h0000_0000, 1'b0, 31'd0},
      '{OP_LOAD_DRAW, 32'h7FFF_FFFF, 1'b1, 31'd0},
      '{OP_LOAD_DRAW, 32'h0000_0005, 1'b0, 31'd0},
      // negative seeds are negated and warmed up
      '{OP_LOAD_DRAW, 32'hFFFF_FFFF, 1'b0, 31'd0},
      '{OP_LOAD_DRAW, 32'h8000_0001, 1'b0, 31'd0},
      '{OP_LOAD_DRAW, 32'h8000_0000, 1'b0, 31'd0},
      '{OP_LOAD_DRAW, 32'h7FFF_FFFE, 1'b0, 31'd0},
      '{OP_DRAW,      32'h1234_5678, 1'b0, 31'd0},
      '{OP_LOAD_DRAW, 32'h0000_3039, 1'b0, 31'd0},
      '{OP_DRAW,      32'h0000_0000, 1'b0, 31'd0},
      '{OP_DRAW,      32'h8000_0000, 1'b0, 31'd0},
      '{OP_LOAD_DRAW, 32'h5555_5555, 1'b0, 31'd0},
      '{OP_LOAD_DRAW, 32'hAAAA_AAAA, 1'b0, 31'd0}
   };

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // generator state as predicted
   logic [30:0] gen_seed;
   logic [30:0] gen_last;
   logic [30:0] shuffle [TABLE_SIZE];

   rsp_type       draw_q [$];
   seed_hint_type pinned_seed_q [$];
   int            mismatch_count = 0;
   int            cycle_count = 0;
   int            idle_pct = 37;

   shuffled_minimal_standard_rng_top #(.TABLE_SIZE(TABLE_SIZE)) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // clock generation
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // exact 16807*s mod (2^31-1), s up to 2^31
   function automatic logic [63:0] lehmer_step(input logic [63:0] s);
      return (s * 64'(MULT)) % 64'(MODULUS);
   endfunction

   // predicted draw for one accepted word; updates the predicted state
   function automatic rsp_type draw_next(input req_type w);
      logic        neg;
      logic [31:0] raw;
      logic [31:0] negated;
      logic [63:0] mag;
      logic [63:0] s;
      logic [63:0] slot;
      logic [63:0] frac;
      rsp_type     r;
      raw = w.seed_value;
      if (w.operation == OP_LOAD_DRAW) begin
         neg = raw[31];
         negated = (~raw) + 32'd1;
         mag = neg ? {32'd0, negated} : {32'd0, raw};
      end else begin
         neg = 1'b0;
         mag = {33'd0, gen_seed};
      end
      // self seeding with warm-up steps
      if (neg || mag == 64'd0 || gen_last == 31'd0) begin
         s = neg ? mag : 64'd1;
         for (int n = TABLE_SIZE + WARM_EXTRA - 1; n >= 0; n--) begin
            s = lehmer_step(s);
            if (n < TABLE_SIZE) shuffle[n] = s[30:0];
         end
         gen_last = shuffle[0];
      end else begin
         s = mag;
      end
      s = lehmer_step(s);
      slot = {33'd0, gen_last} / SLOT_DIV;
      if (slot >= 64'(TABLE_SIZE)) slot = 64'(TABLE_SIZE - 1);
      gen_last = shuffle[slot];
      shuffle[slot] = s[30:0];
      gen_seed = s[30:0];
      frac = ({33'd0, gen_last} << 24) / 64'(MODULUS);
      if (frac > 64'(FRAC_MAX)) frac = 64'(FRAC_MAX);
      r.sample = gen_last;
      r.fraction = frac[23:0];
      r.seed_after = gen_seed;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s at cycle %0d: got %0d, expected %0d",
               what, cycle_count, got, want);
      mismatch_count++;
   endtask

   // result check, then prediction of the word accepted at this edge
   always @(posedge clock) begin
      rsp_type       want;
      seed_hint_type hint;
      if (!reset) begin
         if (rsp_strobe === 1'b1) begin
            if (draw_q.size() == 0) begin
               report_mismatch("result with no word pending", 32'(rsp_data.sample), 32'd0);
            end else begin
               want = draw_q.pop_front();
               if (rsp_data.sample !== want.sample)
                  report_mismatch("sample", 32'(rsp_data.sample), 32'(want.sample));
               if (rsp_data.fraction !== want.fraction)
                  report_mismatch("fraction", 32'(rsp_data.fraction), 32'(want.fraction));
               if (rsp_data.seed_after !== want.seed_after)
                  report_mismatch("seed_after", 32'(rsp_data.seed_after),
                                  32'(want.seed_after));
            end
         end
         if (start === 1'b1 && busy === 1'b0) begin
            hint = pinned_seed_q.pop_front();
            want = draw_next(req_data);
            if (hint.known) want.seed_after = hint.seed_after;
            draw_q.push_back(want);
         end
      end
   end

   // cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // offer one word, with random idle cycles first; returns after its accepting edge
   task automatic send_word(input req_type w, input logic known, input logic [30:0] seed_after);
      seed_hint_type hint;
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         req_data <= '{operation: 1'($urandom), seed_value: $urandom};
         @(posedge clock);
      end
      hint.known = known;
      hint.seed_after = seed_after;
      pinned_seed_q.push_back(hint);
      start <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   // hold off until every pending result has come
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (draw_q.size() != 0) @(posedge clock);
   endtask

   // mostly draws from a seeded generator, with loads, negatives and edge seeds mixed in
   function automatic req_type random_word();
      req_type w;
      int      pick;
      pick = $urandom_range(0, 99);
      w.seed_value = $urandom;
      w.operation = OP_LOAD_DRAW;
      if (pick < 60)      w.operation = OP_DRAW;
      else if (pick < 75) w.seed_value = {1'b0, w.seed_value[30:0]};
      else if (pick < 85) w.seed_value = {1'b1, w.seed_value[30:0]};
      else if (pick < 89) w.seed_value = 32'sh0000_0000;
      else if (pick < 94) w.seed_value = 32'sh7FFF_FFFF;
      else if (pick < 96) w.seed_value = 32'sh8000_0000;
      else                w.seed_value = 32'($urandom_range(1, 255));
      return w;
   endfunction

   // stimulus
   initial begin
      req_type w;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      gen_seed = '0;
      gen_last = '0;
      for (int i = 0; i < TABLE_SIZE; i++) shuffle[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (directed_rows[i]) begin
         w.operation = directed_rows[i].operation;
         w.seed_value = directed_rows[i].seed_value;
         send_word(w, directed_rows[i].pinned, directed_rows[i].seed_after);
      end
      drain_results();

      // random words
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         idle_pct = (i >= 150 && i < 350) ? 0 : 37;
         if (i == 400) drain_results();
         send_word(random_word(), 1'b0, 31'd0);
      end
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (draw_q.size() != 0)
         report_mismatch("results never arrived", 32'(draw_q.size()), 32'd0);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
